### rtl/crfb_pkg.sv
package crfb_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    // coordinate math width, covers origin + position + size without overflow
    localparam int CW  = 16;
    localparam int XCW = $clog2(MAX_WIDTH + 1);
    localparam int YCW = $clog2(MAX_HEIGHT + 1);

    localparam int COLOR_W = 32;
    localparam int COUNT_W = 21;
    localparam int POS_W   = 13;
    localparam int SIZE_W  = 12;
    localparam int FRAME_W = 11;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 3;
    localparam int KIND_W  = 3;

    localparam logic [COLOR_W-1:0] KEY_COLOR = 32'hFF00_0000;

    localparam logic [KIND_W-1:0] KIND_FILL    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OUTLINE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BLIT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
    localparam logic [IDX_W-1:0] REG_CLIP_WIDTH   = 3'd4;
    localparam logic [IDX_W-1:0] REG_CLIP_HEIGHT  = 3'd5;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = 11'd768;
    localparam logic [SIZE_W-1:0]  CLIP_WIDTH_RESET   = 12'd1024;
    localparam logic [SIZE_W-1:0]  CLIP_HEIGHT_RESET  = 12'd768;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t w;
        coord_t h;
    } rect_t;

    typedef struct packed {
        coord_t ox;
        coord_t oy;
        coord_t cw;
        coord_t ch;
        coord_t fw;
        coord_t fh;
    } view_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } wr_t;

endpackage

### rtl/crfb_ram.sv
module crfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/crfb_rect.sv
module crfb_rect (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  crfb_pkg::rect_t  req,
    input  crfb_pkg::view_t  view,
    output crfb_pkg::wr_t    wr,
    output logic             done
);

    typedef enum logic [1:0] {W_IDLE, W_CLAMP, W_BASE, W_RUN} wstate_t;

    wstate_t                          state_reg;
    crfb_pkg::coord_t                 xs_reg, xe_reg, ys_reg, ye_reg;
    crfb_pkg::coord_t                 x0_reg, x1_reg, y0_reg, y1_reg;
    logic [crfb_pkg::XCW-1:0]         cx_reg;
    logic [crfb_pkg::YCW-1:0]         cy_reg;
    logic [crfb_pkg::ADDR_W-1:0]      base_reg;
    logic                             done_reg;

    crfb_pkg::coord_t                 x_end, y_end, xs, xe, ys, ye;
    crfb_pkg::coord_t                 ox_s, ox_e, oy_s, oy_e, x0, x1, y0, y1;
    logic                             empty;
    logic [crfb_pkg::XCW+crfb_pkg::YCW-1:0] prod;
    logic [crfb_pkg::XCW-1:0]         cx_inc;
    logic [crfb_pkg::YCW-1:0]         cy_inc;
    logic                             last_col, last_row;

    // clip right/bottom to the window, clamp left/top at the origin
    always_comb
    begin
        x_end = req.x + req.w;
        y_end = req.y + req.h;
        xs    = (req.x < 0) ? '0 : req.x;
        ys    = (req.y < 0) ? '0 : req.y;
        xe    = (x_end > view.cw) ? view.cw : x_end;
        ye    = (y_end > view.ch) ? view.ch : y_end;
    end

    // move to screen space and clamp to the frame
    always_comb
    begin
        ox_s = view.ox + xs_reg;
        ox_e = view.ox + xe_reg;
        oy_s = view.oy + ys_reg;
        oy_e = view.oy + ye_reg;
        x0   = (ox_s < 0) ? '0 : ox_s;
        y0   = (oy_s < 0) ? '0 : oy_s;
        x1   = (ox_e > view.fw) ? view.fw : ox_e;
        y1   = (oy_e > view.fh) ? view.fh : oy_e;
    end

    // when not empty, x0 < x1 <= fw and y0 < y1 <= fh, so the narrow selects hold
    assign empty = (x0_reg >= x1_reg) || (y0_reg >= y1_reg);
    assign prod  = {{crfb_pkg::XCW{1'b0}}, y0_reg[crfb_pkg::YCW-1:0]}
                 * {{crfb_pkg::YCW{1'b0}}, view.fw[crfb_pkg::XCW-1:0]};

    assign cx_inc   = cx_reg + crfb_pkg::XCW'(1);
    assign cy_inc   = cy_reg + crfb_pkg::YCW'(1);
    assign last_col = (cx_inc == x1_reg[crfb_pkg::XCW-1:0]);
    assign last_row = (cy_inc == y1_reg[crfb_pkg::YCW-1:0]);

    assign wr.en   = (state_reg == W_RUN);
    assign wr.addr = base_reg + crfb_pkg::ADDR_W'(cx_reg);
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                W_IDLE:
                begin
                    if (start)
                    begin
                        xs_reg    <= xs;
                        xe_reg    <= xe;
                        ys_reg    <= ys;
                        ye_reg    <= ye;
                        state_reg <= W_CLAMP;
                    end
                end
                W_CLAMP:
                begin
                    x0_reg    <= x0;
                    x1_reg    <= x1;
                    y0_reg    <= y0;
                    y1_reg    <= y1;
                    state_reg <= W_BASE;
                end
                W_BASE:
                begin
                    if (empty)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= W_IDLE;
                    end
                    else
                    begin
                        base_reg  <= prod[crfb_pkg::ADDR_W-1:0];
                        cx_reg    <= x0_reg[crfb_pkg::XCW-1:0];
                        cy_reg    <= y0_reg[crfb_pkg::YCW-1:0];
                        state_reg <= W_RUN;
                    end
                end
                W_RUN:
                begin
                    if (last_col)
                    begin
                        cx_reg <= x0_reg[crfb_pkg::XCW-1:0];
                        if (last_row)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= W_IDLE;
                        end
                        else
                        begin
                            cy_reg   <= cy_inc;
                            base_reg <= base_reg
                                      + crfb_pkg::ADDR_W'(view.fw[crfb_pkg::XCW-1:0]);
                        end
                    end
                    else
                    begin
                        cx_reg <= cx_inc;
                    end
                end
                default:
                begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

    a_run_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == W_RUN) |->
            (cx_reg < x1_reg[crfb_pkg::XCW-1:0]) && (cy_reg < y1_reg[crfb_pkg::YCW-1:0]))
        else $error("rect scan left its bounds");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == W_IDLE))
        else $error("rect done while still scanning");

endmodule

### rtl/clipped_raster_fill_and_keyed_blit_top.sv
// from accept to the done strobe: pixels, blits, fills and outlines run clipped rectangle
// scans (an outline one per edge), reads pass the multiply, issue and wait states, and keyed
// blits, empty outlines and blits and unknown kinds end without a scan; one command at a time
// throughput: one frame store write per cycle during a scan, set by its single write port
// reset: rst_n clears control, blit counters and registers to their defaults; frame store
// contents are not cleared. the done strobe lasts one cycle and the receiver cannot stall
module clipped_raster_fill_and_keyed_blit_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [crfb_pkg::KIND_W-1:0]          kind,
    input  logic signed [crfb_pkg::POS_W-1:0]    pos_x,
    input  logic signed [crfb_pkg::POS_W-1:0]    pos_y,
    input  logic [crfb_pkg::SIZE_W-1:0]          width,
    input  logic [crfb_pkg::SIZE_W-1:0]          height,
    input  logic [crfb_pkg::COLOR_W-1:0]         color,
    input  logic                                 cfg_we,
    input  logic [crfb_pkg::IDX_W-1:0]           cfg_index,
    input  logic [crfb_pkg::CFG_W-1:0]           cfg_data,
    output logic                                 done,
    output logic [crfb_pkg::COLOR_W-1:0]         read_color,
    output logic [crfb_pkg::COUNT_W-1:0]         pixels_written,
    output logic                                 blit_done
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_RD_MUL, ST_RD_ISSUE, ST_RD_WAIT
    } state_t;

    typedef enum logic [1:0] {EDGE_TOP, EDGE_BOTTOM, EDGE_LEFT, EDGE_RIGHT} edge_t;

    // configuration
    logic [crfb_pkg::FRAME_W-1:0]      fw_reg, fh_reg;
    logic signed [crfb_pkg::POS_W-1:0] ox_reg, oy_reg;
    logic [crfb_pkg::SIZE_W-1:0]       cw_reg, ch_reg;

    state_t                            state_reg;
    edge_t                             edge_reg;
    logic [crfb_pkg::KIND_W-1:0]       kind_reg;
    crfb_pkg::coord_t                  lx_reg, ly_reg, lw_reg, lh_reg;
    logic [crfb_pkg::COLOR_W-1:0]      color_reg;
    logic [crfb_pkg::SIZE_W-1:0]       col_reg, row_reg;
    logic [crfb_pkg::ADDR_W-1:0]       rd_base_reg;
    logic                              rd_ok_reg;
    logic                              done_reg;
    logic [crfb_pkg::COLOR_W-1:0]      read_color_reg;
    logic [crfb_pkg::COUNT_W-1:0]      cnt_reg;
    logic                              blit_done_reg;

    crfb_pkg::coord_t                  fw_ext, fh_ext, fw_eff, fh_eff;
    crfb_pkg::coord_t                  px, py, wc, hc, colc, rowc;
    crfb_pkg::view_t                   view;
    crfb_pkg::rect_t                   req;
    crfb_pkg::wr_t                     wr;
    logic                              rect_start, rect_done;
    logic [crfb_pkg::SIZE_W:0]         col_inc, row_inc;
    logic                              col_wrap, row_wrap;
    logic                              rd_ok;
    logic [crfb_pkg::XCW+crfb_pkg::YCW-1:0] rd_prod;
    logic [crfb_pkg::ADDR_W-1:0]       raddr;
    logic [crfb_pkg::COLOR_W-1:0]      rdata;

    // frame size beyond the store acts as the store size
    assign fw_ext = crfb_pkg::CW'(fw_reg);
    assign fh_ext = crfb_pkg::CW'(fh_reg);
    assign fw_eff = (fw_ext > crfb_pkg::CW'(crfb_pkg::MAX_WIDTH))
                  ? crfb_pkg::CW'(crfb_pkg::MAX_WIDTH) : fw_ext;
    assign fh_eff = (fh_ext > crfb_pkg::CW'(crfb_pkg::MAX_HEIGHT))
                  ? crfb_pkg::CW'(crfb_pkg::MAX_HEIGHT) : fh_ext;

    assign view.ox = crfb_pkg::CW'(ox_reg);
    assign view.oy = crfb_pkg::CW'(oy_reg);
    assign view.cw = $signed({{(crfb_pkg::CW-crfb_pkg::SIZE_W){1'b0}}, cw_reg});
    assign view.ch = $signed({{(crfb_pkg::CW-crfb_pkg::SIZE_W){1'b0}}, ch_reg});
    assign view.fw = fw_eff;
    assign view.fh = fh_eff;

    assign px   = crfb_pkg::CW'(pos_x);
    assign py   = crfb_pkg::CW'(pos_y);
    assign wc   = $signed({{(crfb_pkg::CW-crfb_pkg::SIZE_W){1'b0}}, width});
    assign hc   = $signed({{(crfb_pkg::CW-crfb_pkg::SIZE_W){1'b0}}, height});
    assign colc = $signed({{(crfb_pkg::CW-crfb_pkg::SIZE_W){1'b0}}, col_reg});
    assign rowc = $signed({{(crfb_pkg::CW-crfb_pkg::SIZE_W){1'b0}}, row_reg});

    // blit counters use reached-or-passed so a size change mid-blit still ends it
    assign col_inc  = {1'b0, col_reg} + (crfb_pkg::SIZE_W+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (crfb_pkg::SIZE_W+1)'(1);
    assign col_wrap = (col_inc >= {1'b0, width});
    assign row_wrap = (row_inc >= {1'b0, height});

    // outline edges are four clipped fills
    always_comb
    begin
        req.x = lx_reg;
        req.y = ly_reg;
        req.w = lw_reg;
        req.h = lh_reg;
        if (kind_reg == crfb_pkg::KIND_OUTLINE)
        begin
            unique case (edge_reg)
                EDGE_TOP:
                begin
                    req.h = crfb_pkg::CW'(1);
                end
                EDGE_BOTTOM:
                begin
                    req.y = ly_reg + lh_reg - crfb_pkg::CW'(1);
                    req.h = crfb_pkg::CW'(1);
                end
                EDGE_LEFT:
                begin
                    req.w = crfb_pkg::CW'(1);
                end
                EDGE_RIGHT:
                begin
                    req.x = lx_reg + lw_reg - crfb_pkg::CW'(1);
                    req.w = crfb_pkg::CW'(1);
                end
                default:
                begin
                    req.w = '0;
                end
            endcase
        end
    end

    assign rect_start = (state_reg == ST_ISSUE);

    crfb_rect u_rect (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rect_start),
        .req   (req),
        .view  (view),
        .wr    (wr),
        .done  (rect_done)
    );

    assign rd_ok   = (lx_reg >= 0) && (ly_reg >= 0) && (lx_reg < fw_eff) && (ly_reg < fh_eff);
    assign rd_prod = {{crfb_pkg::XCW{1'b0}}, ly_reg[crfb_pkg::YCW-1:0]}
                   * {{crfb_pkg::YCW{1'b0}}, fw_eff[crfb_pkg::XCW-1:0]};
    assign raddr   = rd_base_reg + crfb_pkg::ADDR_W'(lx_reg[crfb_pkg::XCW-1:0]);

    // reads and writes belong to different commands, so they never meet on one word
    crfb_ram #(
        .WIDTH (crfb_pkg::COLOR_W),
        .DEPTH (crfb_pkg::STORE_WORDS)
    ) u_frame (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (color_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= crfb_pkg::FRAME_WIDTH_RESET;
            fh_reg <= crfb_pkg::FRAME_HEIGHT_RESET;
            ox_reg <= '0;
            oy_reg <= '0;
            cw_reg <= crfb_pkg::CLIP_WIDTH_RESET;
            ch_reg <= crfb_pkg::CLIP_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crfb_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg_data[crfb_pkg::FRAME_W-1:0];
                crfb_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_data[crfb_pkg::FRAME_W-1:0];
                crfb_pkg::REG_ORIGIN_X:     ox_reg <= $signed(cfg_data);
                crfb_pkg::REG_ORIGIN_Y:     oy_reg <= $signed(cfg_data);
                crfb_pkg::REG_CLIP_WIDTH:   cw_reg <= cfg_data[crfb_pkg::SIZE_W-1:0];
                crfb_pkg::REG_CLIP_HEIGHT:  ch_reg <= cfg_data[crfb_pkg::SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            edge_reg       <= EDGE_TOP;
            col_reg        <= '0;
            row_reg        <= '0;
            done_reg       <= 1'b0;
            cnt_reg        <= '0;
            read_color_reg <= '0;
            blit_done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (wr.en)
            begin
                cnt_reg <= cnt_reg + crfb_pkg::COUNT_W'(1);
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg       <= kind;
                        color_reg      <= color;
                        lx_reg         <= px;
                        ly_reg         <= py;
                        lw_reg         <= wc;
                        lh_reg         <= hc;
                        edge_reg       <= EDGE_TOP;
                        cnt_reg        <= '0;
                        read_color_reg <= '0;
                        blit_done_reg  <= 1'b0;
                        case (kind)
                            crfb_pkg::KIND_FILL:
                            begin
                                state_reg <= ST_ISSUE;
                            end
                            crfb_pkg::KIND_OUTLINE:
                            begin
                                if (width == '0 || height == '0)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_ISSUE;
                                end
                            end
                            crfb_pkg::KIND_PIXEL:
                            begin
                                lw_reg    <= crfb_pkg::CW'(1);
                                lh_reg    <= crfb_pkg::CW'(1);
                                state_reg <= ST_ISSUE;
                            end
                            crfb_pkg::KIND_BLIT:
                            begin
                                lx_reg <= px + colc;
                                ly_reg <= py + rowc;
                                lw_reg <= crfb_pkg::CW'(1);
                                lh_reg <= crfb_pkg::CW'(1);
                                if (width == '0 || height == '0)
                                begin
                                    col_reg       <= '0;
                                    row_reg       <= '0;
                                    blit_done_reg <= 1'b1;
                                    done_reg      <= 1'b1;
                                end
                                else
                                begin
                                    if (col_wrap)
                                    begin
                                        col_reg <= '0;
                                        if (row_wrap)
                                        begin
                                            row_reg       <= '0;
                                            blit_done_reg <= 1'b1;
                                        end
                                        else
                                        begin
                                            row_reg <= row_inc[crfb_pkg::SIZE_W-1:0];
                                        end
                                    end
                                    else
                                    begin
                                        col_reg <= col_inc[crfb_pkg::SIZE_W-1:0];
                                    end
                                    // the key color is transparent
                                    if (color == crfb_pkg::KEY_COLOR)
                                    begin
                                        done_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_ISSUE;
                                    end
                                end
                            end
                            crfb_pkg::KIND_READ:
                            begin
                                state_reg <= ST_RD_MUL;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (rect_done)
                    begin
                        if (kind_reg == crfb_pkg::KIND_OUTLINE && edge_reg != EDGE_RIGHT)
                        begin
                            unique case (edge_reg)
                                EDGE_TOP:    edge_reg <= EDGE_BOTTOM;
                                EDGE_BOTTOM: edge_reg <= EDGE_LEFT;
                                default:     edge_reg <= EDGE_RIGHT;
                            endcase
                            state_reg <= ST_ISSUE;
                        end
                        else
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_RD_MUL:
                begin
                    rd_ok_reg   <= rd_ok;
                    rd_base_reg <= rd_prod[crfb_pkg::ADDR_W-1:0];
                    state_reg   <= ST_RD_ISSUE;
                end
                ST_RD_ISSUE:
                begin
                    state_reg <= ST_RD_WAIT;
                end
                ST_RD_WAIT:
                begin
                    read_color_reg <= rd_ok_reg ? rdata : '0;
                    done_reg       <= 1'b1;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign read_color     = read_color_reg;
    assign pixels_written = cnt_reg;
    assign blit_done      = blit_done_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a command is in flight");

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == ST_WAIT))
        else $error("frame store write outside a rectangle scan");

    a_fill_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == crfb_pkg::KIND_FILL || kind == crfb_pkg::KIND_READ))
            |=> busy)
        else $error("fill or read transfer did not start work");

    a_read_writes_none: assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_color != '0) |-> (pixels_written == '0) && !blit_done)
        else $error("read result carries write count");

endmodule
